>>> rtl/jbt_pkg.sv
// Package: token codes, scan modes, result type and character helpers of the tokenizer.
package jbt_pkg;

  typedef enum logic [3:0] {
    TT_NUMBER   = 4'd0,
    TT_STRING   = 4'd1,
    TT_LBRACE   = 4'd2,
    TT_RBRACE   = 4'd3,
    TT_LBRACKET = 4'd4,
    TT_RBRACKET = 4'd5,
    TT_COLON    = 4'd6,
    TT_COMMA    = 4'd7,
    TT_TRUE     = 4'd8,
    TT_FALSE    = 4'd9,
    TT_NULL     = 4'd10,
    TT_END      = 4'd11
  } tok_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_WORD = 2'd3
  } mode_t;

  typedef struct packed {
    logic [3:0] token_type;
    logic [7:0] text_byte;
    logic       is_text;
    logic       is_last;
  } result_t;

  typedef struct packed {
    logic hit;
    tok_t tt;
  } punct_t;

  localparam int unsigned QueueDepth = 3;
  localparam logic [7:0] ChEnd    = 8'h00;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [2:0] CandAll  = 3'b111;
  localparam logic [2:0] LenMax   = 3'd7;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // Single-byte tokens seen between tokens, including end of text.
  function automatic punct_t punct(input logic [7:0] b);
    punct_t p;
    p.hit = 1'b1;
    p.tt  = TT_END;
    case (b)
      ChEnd:   p.tt = TT_END;
      "{":     p.tt = TT_LBRACE;
      "}":     p.tt = TT_RBRACE;
      "[":     p.tt = TT_LBRACKET;
      "]":     p.tt = TT_RBRACKET;
      ",":     p.tt = TT_COMMA;
      ":":     p.tt = TT_COLON;
      default: p.hit = 1'b0;
    endcase
    return p;
  endfunction

  // Keyword spelling: index 0 true, 1 false, 2 null; 0 past the end.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: begin
        case (pos)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      2'd0:    n = 3'd4;
      2'd1:    n = 3'd5;
      2'd2:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/jbt_in_if.sv
// Interface: input byte channel with valid/ready handshake.
interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

>>> rtl/jbt_out_if.sv
// Interface: token result channel with valid/ready handshake.
interface jbt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_type;
  logic [7:0] text_byte;
  logic       is_text;
  logic       is_last;

  modport source (output valid, output token_type, output text_byte, output is_text,
                  output is_last, input ready);
  modport sink (input valid, input token_type, input text_byte, input is_text,
                input is_last, output ready);
endinterface

>>> rtl/json_byte_tokenizer_core.sv
// Streaming JSON tokenizer: one text byte in, token text bytes and token types out.
// The core takes one text byte per cycle while the input is ready, and registers its
// results. Each byte gives zero, one or two result beats; the results go into a
// three-entry result queue, and the input is ready whenever at most one result waits
// there, so a byte is accepted even while the output is stalled. A byte that closes a
// bare word on a comma, right brace, right bracket or end of text, or that ends text
// inside a string, gives two beats, which drain at one per cycle while the output is
// ready; the output then sets the pace.
module json_byte_tokenizer_core
  import jbt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  jbt_in_if.sink        in_bus,
  jbt_out_if.source     out_bus
);

  mode_t      mode_r, mode_nxt;
  logic [2:0] cand_r, cand_nxt;
  logic [2:0] len_r, len_nxt;
  logic [1:0] count_r, count_nxt;
  result_t    q_r [QueueDepth];
  result_t    q_nxt [QueueDepth];

  logic       accept, pop;
  logic [7:0] b;
  result_t    res0, res1;
  logic [1:0] n_res;
  punct_t     pb;
  logic [2:0] wcand, wlen;
  logic [3:0] wclass;
  logic [1:0] cnt_after;

  assign b      = in_bus.in_byte;
  assign accept = in_bus.valid && in_bus.ready;
  assign pop    = out_bus.valid && out_bus.ready;
  assign pb     = punct(b);

  assign in_bus.ready       = (count_r <= 2'd1);
  assign out_bus.valid      = (count_r != 2'd0);
  assign out_bus.token_type = q_r[0].token_type;
  assign out_bus.text_byte  = q_r[0].text_byte;
  assign out_bus.is_text    = q_r[0].is_text;
  assign out_bus.is_last    = q_r[0].is_last;

  // Class of the word as it stands, before this byte.
  always_comb begin
    wclass = TT_NUMBER;
    if (cand_r[2] && (len_r == kw_len(2'd2))) wclass = TT_NULL;
    if (cand_r[1] && (len_r == kw_len(2'd1))) wclass = TT_FALSE;
    if (cand_r[0] && (len_r == kw_len(2'd0))) wclass = TT_TRUE;
  end

  // Keyword candidates and length after taking this byte into a word.
  always_comb begin
    logic [2:0] base_cand;
    logic [2:0] base_len;
    base_cand = (mode_r == MODE_WORD) ? cand_r : CandAll;
    base_len  = (mode_r == MODE_WORD) ? len_r : 3'd0;
    wcand     = base_cand;
    for (int k = 0; k < 3; k++) begin
      if ((base_len >= kw_len(2'(k))) || (kw_char(2'(k), base_len) != b)) begin
        wcand[k] = 1'b0;
      end
    end
    wlen = (base_len < LenMax) ? base_len + 3'd1 : base_len;
  end

  always_comb begin
    mode_nxt = mode_r;
    cand_nxt = cand_r;
    len_nxt  = len_r;
    res0     = '0;
    res1     = '0;
    n_res    = 2'd0;
    case (mode_r)
      MODE_IDLE: begin
        if (pb.hit) begin
          res0.token_type = pb.tt;
          n_res = 2'd1;
        end else if (b == ChQuote) begin
          mode_nxt = MODE_STR;
        end else if (!is_ws(b)) begin
          mode_nxt = MODE_WORD;
          cand_nxt = wcand;
          len_nxt  = wlen;
          res0.text_byte = b;
          res0.is_text   = 1'b1;
          n_res = 2'd1;
        end
      end
      MODE_STR, MODE_ESC: begin
        if (b == ChEnd) begin
          res0.token_type = TT_STRING;
          res1.token_type = TT_END;
          mode_nxt = MODE_IDLE;
          n_res = 2'd2;
        end else if ((mode_r == MODE_STR) && (b == ChQuote)) begin
          res0.token_type = TT_STRING;
          mode_nxt = MODE_IDLE;
          n_res = 2'd1;
        end else begin
          mode_nxt = ((mode_r == MODE_STR) && (b == ChBslash)) ? MODE_ESC : MODE_STR;
          res0.text_byte = b;
          res0.is_text   = 1'b1;
          n_res = 2'd1;
        end
      end
      MODE_WORD: begin
        if (pb.hit || is_ws(b)) begin
          // A colon or a left brace/bracket never ends a word; such a hit is taken into the word as text.
          if ((b == ChEnd) || (b == ",") || (b == "}") || (b == "]") || is_ws(b)) begin
            res0.token_type = wclass;
            mode_nxt = MODE_IDLE;
            cand_nxt = CandAll;
            len_nxt  = 3'd0;
            if (is_ws(b)) begin
              n_res = 2'd1;
            end else begin
              res1.token_type = pb.tt;
              n_res = 2'd2;
            end
          end else begin
            cand_nxt = wcand;
            len_nxt  = wlen;
            res0.text_byte = b;
            res0.is_text   = 1'b1;
            n_res = 2'd1;
          end
        end else begin
          cand_nxt = wcand;
          len_nxt  = wlen;
          res0.text_byte = b;
          res0.is_text   = 1'b1;
          n_res = 2'd1;
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase
    if (n_res == 2'd1) res0.is_last = 1'b1;
    if (n_res == 2'd2) res1.is_last = 1'b1;
    if (!accept) begin
      mode_nxt = mode_r;
      cand_nxt = cand_r;
      len_nxt  = len_r;
      n_res    = 2'd0;
    end
  end

  // Result queue: entry 0 is the head shown on the output; new results append behind.
  always_comb begin
    cnt_after = count_r - {1'b0, pop};
    q_nxt[0]  = pop ? q_r[1] : q_r[0];
    q_nxt[1]  = pop ? q_r[2] : q_r[1];
    q_nxt[2]  = q_r[2];
    for (int i = 0; i < QueueDepth; i++) begin
      if ((n_res != 2'd0) && (cnt_after == 2'(i))) begin
        q_nxt[i] = res0;
      end
      if ((n_res == 2'd2) && ((cnt_after + 2'd1) == 2'(i))) begin
        q_nxt[i] = res1;
      end
    end
    count_nxt = cnt_after + n_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      cand_r  <= CandAll;
      len_r   <= 3'd0;
      count_r <= 2'd0;
    end else begin
      mode_r  <= mode_nxt;
      cand_r  <= cand_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QueueDepth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (count_r <= 2'd1))
    else $error("byte accepted without room for two results");

  a_quote_opens_string: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (mode_r == MODE_IDLE) && (b == ChQuote)) |=> (mode_r == MODE_STR))
    else $error("quote between tokens did not open a string");

  a_len_only_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_WORD) |-> ((len_r == 3'd0) && (cand_r == CandAll)))
    else $error("word state left over outside a word");

  a_long_word_no_keyword: assert property (@(posedge clk) disable iff (!rst_n)
    ((mode_r == MODE_WORD) && (len_r > 3'd5)) |-> (cand_r == 3'd0))
    else $error("keyword candidate kept past keyword length");

  a_two_results_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (n_res == 2'd2) && !pop) |=> (count_r >= 2'd2))
    else $error("two-result byte lost a beat");

endmodule
